>>> rtl/core/edr_pkg.sv
// Shared types and constants of the edit distance ratio engine.
// Used by edr_dp_seq, edr_div and the top level in rtl/core; depends on nothing else.
`default_nettype none

package edr_pkg;

  // Default string capacity in characters.
  localparam int MAX_LEN_DEF = 64;

  // Widths of the result fields.
  localparam int DIST_W  = 7;
  localparam int LEN_W   = 7;
  localparam int RATIO_W = 17;
  localparam int CHAR_W  = 8;

  // Fraction bits of the ratio and the value that stands for 1.0.
  localparam int FRAC_BITS = 16;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  // Request operation codes.
  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE       = 2'd2;

  // Status that an iterative unit reports to the control logic.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

`default_nettype wire

>>> rtl/core/edr_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Used for the character stores and the cost row; depends on nothing else.
`default_nettype none

module edr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/edr_dp_seq.sv
// Sequencer of the edit distance dynamic program over a single cost row.
// Depends on edr_pkg and edr_ram; reads the character stores of the top level.
`default_nettype none

module edr_dp_seq #(
  parameter int MAX_LEN = edr_pkg::MAX_LEN_DEF,
  parameter int CW      = $clog2(MAX_LEN + 1),
  parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [CW-1:0]         first_len_i,
  input  wire logic [CW-1:0]         second_len_i,
  output logic                       first_re_o,
  output logic      [AW-1:0]         first_raddr_o,
  input  wire logic [edr_pkg::CHAR_W-1:0] first_rdata_i,
  output logic                       second_re_o,
  output logic      [AW-1:0]         second_raddr_o,
  input  wire logic [edr_pkg::CHAR_W-1:0] second_rdata_i,
  output edr_pkg::unit_status_t      status_o,
  output logic      [CW-1:0]         dist_o
);

  typedef enum logic [4:0] {
    SQ_IDLE = 5'b00001,
    SQ_INIT = 5'b00010,
    SQ_ROW  = 5'b00100,
    SQ_RD   = 5'b01000,
    SQ_WR   = 5'b10000
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [CW-1:0] diag_q, diag_d, left_q, left_d;
  logic          done_q, done_d;

  logic          row_we, row_re;
  logic [CW-1:0] row_waddr, row_wdata, row_raddr, row_rdata;
  logic [CW-1:0] i_m1, j_m1;
  logic [CW:0]   above_inc, left_inc, sub_cost, min_ab, min_all;

  edr_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_LEN + 1),
    .AW   (CW)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(row_waddr),
    .wdata_i(row_wdata),
    .re_i   (row_re),
    .raddr_i(row_raddr),
    .rdata_o(row_rdata)
  );

  assign i_m1 = i_q - CW'(1);
  assign j_m1 = j_q - CW'(1);

  // One cell: the cheapest of deletion, insertion and substitution.
  assign above_inc = {1'b0, row_rdata} + (CW+1)'(1);
  assign left_inc  = {1'b0, left_q} + (CW+1)'(1);
  assign sub_cost  = {1'b0, diag_q} + (CW+1)'(first_rdata_i != second_rdata_i);
  assign min_ab    = (above_inc < left_inc) ? above_inc : left_inc;
  assign min_all   = (min_ab < sub_cost) ? min_ab : sub_cost;

  assign first_re_o     = (state_q == SQ_ROW);
  assign first_raddr_o  = i_m1[AW-1:0];
  assign second_re_o    = (state_q == SQ_RD);
  assign second_raddr_o = j_m1[AW-1:0];
  assign row_re         = (state_q == SQ_RD);
  assign row_raddr      = j_q;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    diag_d    = diag_q;
    left_d    = left_q;
    done_d    = 1'b0;
    row_we    = 1'b0;
    row_waddr = j_q;
    row_wdata = j_q;
    case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          j_d     = '0;
          state_d = SQ_INIT;
        end
      end
      SQ_INIT: begin
        row_we = 1'b1;
        if (j_q == second_len_i) begin
          if (first_len_i == '0) begin
            left_d  = second_len_i;
            done_d  = 1'b1;
            state_d = SQ_IDLE;
          end else begin
            i_d     = CW'(1);
            state_d = SQ_ROW;
          end
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      SQ_ROW: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = i_q;
        diag_d    = i_m1;
        left_d    = i_q;
        j_d       = CW'(1);
        if (second_len_i == '0) begin
          if (i_q == first_len_i) begin
            done_d  = 1'b1;
            state_d = SQ_IDLE;
          end else begin
            i_d = i_q + CW'(1);
          end
        end else begin
          state_d = SQ_RD;
        end
      end
      SQ_RD: begin
        state_d = SQ_WR;
      end
      SQ_WR: begin
        row_we    = 1'b1;
        row_wdata = min_all[CW-1:0];
        left_d    = min_all[CW-1:0];
        diag_d    = row_rdata;
        if (j_q == second_len_i) begin
          if (i_q == first_len_i) begin
            done_d  = 1'b1;
            state_d = SQ_IDLE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = SQ_ROW;
          end
        end else begin
          j_d     = j_q + CW'(1);
          state_d = SQ_RD;
        end
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    diag_q <= diag_d;
    left_q <= left_d;
  end

  assign status_o.busy = (state_q != SQ_IDLE);
  assign status_o.done = done_q;
  assign dist_o        = left_q;

endmodule

`default_nettype wire

>>> rtl/core/edr_div.sv
// Restoring divider that forms the Q1.16 ratio one quotient bit per cycle.
// Depends on edr_pkg.
`default_nettype none

module edr_div #(
  parameter int MAX_LEN = edr_pkg::MAX_LEN_DEF,
  parameter int CW      = $clog2(MAX_LEN + 1),
  parameter int NW      = CW + edr_pkg::FRAC_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [CW-1:0] numer_i,
  input  wire logic [CW-1:0] denom_i,
  output edr_pkg::unit_status_t status_o,
  output logic      [NW-1:0] quot_o
);

  localparam int SW = $clog2(NW + 1);
  localparam int FracBits = edr_pkg::FRAC_BITS;

  logic [NW-1:0] shreg_q;
  logic [CW-1:0] rem_q, denom_q;
  logic [SW-1:0] steps_q;
  logic          busy_q, done_q;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem_q, shreg_q[NW-1]};
  assign fits  = (trial >= {1'b0, denom_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q  <= 1'b1;
        steps_q <= SW'(NW);
      end else if (busy_q) begin
        steps_q <= steps_q - SW'(1);
        if (steps_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      shreg_q <= {numer_i, {FracBits{1'b0}}};
      rem_q   <= '0;
      denom_q <= denom_i;
    end else if (busy_q) begin
      shreg_q <= {shreg_q[NW-2:0], fits};
      rem_q   <= fits ? CW'(trial - {1'b0, denom_q}) : trial[CW-1:0];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = shreg_q;

endmodule

`default_nettype wire

>>> rtl/core/edit_distance_ratio_engine_top.sv
// Top level of the edit distance ratio engine: request intake, character
// stores, result register. Depends on edr_pkg, edr_ram, edr_dp_seq, edr_div.
//
// Usage. Requests arrive on the input channel (in_valid_i, in_stall_o,
// op_i, ch_i). An append request (op 0 or 1) stores ch_i at the end of the
// first or second string; the block stays ready. A character beyond
// MAX_LEN is dropped and the truncation flag is raised. A compute request
// (op 2) stalls the input channel until its result is loaded into the
// output register. The row sweep first seeds the cost row and then, for
// each character of the first string, computes one cell per character of
// the second string, each cell in a read state and a write state of the
// cost row RAM. The restoring divider then forms the ratio. When both
// strings are empty, the sweep and the divider are skipped.
// The result is held in an output register (out_valid_o, out_stall_i and the
// field ports). Append requests are taken while it waits; a later compute
// finishes its work and then holds until the receiver takes the earlier
// result. Emitting a result clears both strings and the truncation flag.
// Reset empties both strings, clears the flag and drops any pending result;
// the character stores themselves are not cleared.
`default_nettype none

module edit_distance_ratio_engine_top #(
  parameter int MAX_LEN = edr_pkg::MAX_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   op_i,
  input  wire logic [edr_pkg::CHAR_W-1:0]   ch_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [edr_pkg::DIST_W-1:0]   distance_o,
  output logic      [edr_pkg::LEN_W-1:0]    longer_length_o,
  output logic      [edr_pkg::RATIO_W-1:0]  ratio_o,
  output logic                              truncated_o
);

  localparam int CW      = $clog2(MAX_LEN + 1);
  localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int NW      = CW + edr_pkg::FRAC_BITS;
  localparam int DistW   = edr_pkg::DIST_W;
  localparam int LenW    = edr_pkg::LEN_W;
  localparam int RatioW  = edr_pkg::RATIO_W;

  // Control states: idle and taking requests, running the row sweep,
  // dividing, and waiting to hand the result to the output register.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DP   = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } top_state_e;

  top_state_e    state_q, state_d;
  logic [CW-1:0] first_count_q, first_count_d;
  logic [CW-1:0] second_count_q, second_count_d;
  logic          dropped_q, dropped_d;
  logic [CW-1:0] longer_q, longer_d;
  logic [CW-1:0] dist_q, dist_d;

  logic          out_valid_q;
  logic [DistW-1:0]  out_dist_q;
  logic [LenW-1:0]   out_len_q;
  logic [RatioW-1:0] out_ratio_q;
  logic          out_trunc_q;

  logic req_accept, out_free, out_load;
  logic first_we, second_we;
  logic seq_start, div_start;
  logic first_full, second_full;

  logic                       first_re, second_re;
  logic [AW-1:0]              first_raddr, second_raddr;
  logic [edr_pkg::CHAR_W-1:0] first_rdata, second_rdata;
  edr_pkg::unit_status_t      seq_status, div_status;
  logic [CW-1:0]              seq_dist;
  logic [NW-1:0]              div_quot;

  assign in_stall_o  = (state_q != S_IDLE);
  assign req_accept  = in_valid_i && !in_stall_o;
  assign first_full  = (first_count_q == CW'(MAX_LEN));
  assign second_full = (second_count_q == CW'(MAX_LEN));
  assign first_we    = req_accept && (op_i == edr_pkg::OP_APPEND_FIRST) && !first_full;
  assign second_we   = req_accept && (op_i == edr_pkg::OP_APPEND_SECOND) && !second_full;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_EMIT) && out_free;

  edr_ram #(
    .WIDTH(edr_pkg::CHAR_W),
    .DEPTH(MAX_LEN),
    .AW   (AW)
  ) u_first_ram (
    .clk_i  (clk_i),
    .we_i   (first_we),
    .waddr_i(first_count_q[AW-1:0]),
    .wdata_i(ch_i),
    .re_i   (first_re),
    .raddr_i(first_raddr),
    .rdata_o(first_rdata)
  );

  edr_ram #(
    .WIDTH(edr_pkg::CHAR_W),
    .DEPTH(MAX_LEN),
    .AW   (AW)
  ) u_second_ram (
    .clk_i  (clk_i),
    .we_i   (second_we),
    .waddr_i(second_count_q[AW-1:0]),
    .wdata_i(ch_i),
    .re_i   (second_re),
    .raddr_i(second_raddr),
    .rdata_o(second_rdata)
  );

  edr_dp_seq #(
    .MAX_LEN(MAX_LEN),
    .CW     (CW),
    .AW     (AW)
  ) u_dp_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (seq_start),
    .first_len_i   (first_count_q),
    .second_len_i  (second_count_q),
    .first_re_o    (first_re),
    .first_raddr_o (first_raddr),
    .first_rdata_i (first_rdata),
    .second_re_o   (second_re),
    .second_raddr_o(second_raddr),
    .second_rdata_i(second_rdata),
    .status_o      (seq_status),
    .dist_o        (seq_dist)
  );

  // The divider starts in the same cycle that the sweep reports done, taking
  // the distance straight from the sequencer.
  assign div_start = (state_q == S_DP) && seq_status.done;

  edr_div #(
    .MAX_LEN(MAX_LEN),
    .CW     (CW),
    .NW     (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (seq_dist),
    .denom_i (longer_q),
    .status_o(div_status),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d        = state_q;
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    dropped_d      = dropped_q;
    longer_d       = longer_q;
    dist_d         = dist_q;
    seq_start      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          case (op_i)
            edr_pkg::OP_APPEND_FIRST: begin
              if (first_full) begin
                dropped_d = 1'b1;
              end else begin
                first_count_d = first_count_q + CW'(1);
              end
            end
            edr_pkg::OP_APPEND_SECOND: begin
              if (second_full) begin
                dropped_d = 1'b1;
              end else begin
                second_count_d = second_count_q + CW'(1);
              end
            end
            edr_pkg::OP_COMPUTE: begin
              longer_d = (first_count_q > second_count_q) ? first_count_q : second_count_q;
              dist_d   = '0;
              if ((first_count_q == '0) && (second_count_q == '0)) begin
                // Two empty strings need no sweep: distance and ratio are zero.
                state_d = S_EMIT;
              end else begin
                seq_start = 1'b1;
                state_d   = S_DP;
              end
            end
            default: begin
              // The unused code is taken and ignored.
            end
          endcase
        end
      end
      S_DP: begin
        if (seq_status.done) begin
          dist_d  = seq_dist;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          first_count_d  = '0;
          second_count_d = '0;
          dropped_d      = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      first_count_q  <= '0;
      second_count_q <= '0;
      dropped_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      dropped_q      <= dropped_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    longer_q <= longer_d;
    dist_q   <= dist_d;
    if (out_load) begin
      out_dist_q  <= DistW'(dist_q);
      out_len_q   <= LenW'(longer_q);
      out_ratio_q <= (longer_q == '0) ? '0 : RatioW'(div_quot);
      out_trunc_q <= dropped_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign distance_o      = out_dist_q;
  assign longer_length_o = out_len_q;
  assign ratio_o         = out_ratio_q;
  assign truncated_o     = out_trunc_q;

`ifndef SYNTHESIS
  // The sweep only reports completion while the control waits for it.
  a_seq_done_in_dp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_status.done |-> (state_q == S_DP))
    else $error("row sweep finished outside the sweep state");

  // The divider only reports completion while the control waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  // String lengths never pass the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_count_q <= CW'(MAX_LEN)) && (second_count_q <= CW'(MAX_LEN)))
    else $error("string length beyond capacity");

  // Handing a result over leaves both strings empty and the flag clear.
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (first_count_q == '0) && (second_count_q == '0) && !dropped_q)
    else $error("strings not cleared after a result");

  // The distance never exceeds the longer length, so the ratio stays at or below one.
  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ratio_o <= edr_pkg::RATIO_ONE))
    else $error("ratio above one");
`endif

endmodule

`default_nettype wire

>>> tb/edit_distance_ratio_checker.sv
// Scoreboard for the edit distance ratio engine: watches both channels, keeps its own copy
// of the two strings, scores each compute request and compares the emitted results.
// Depends on edr_pkg only.
`timescale 1ns / 100ps

module edit_distance_ratio_checker #(
  parameter int MAX_LEN = edr_pkg::MAX_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire logic [1:0]                   op_i,
  input  wire logic [edr_pkg::CHAR_W-1:0]   ch_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire logic [edr_pkg::DIST_W-1:0]   distance_i,
  input  wire logic [edr_pkg::LEN_W-1:0]    longer_length_i,
  input  wire logic [edr_pkg::RATIO_W-1:0]  ratio_i,
  input  wire logic                         truncated_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);

  localparam int CharW  = edr_pkg::CHAR_W;
  localparam int DistW  = edr_pkg::DIST_W;
  localparam int LenW   = edr_pkg::LEN_W;
  localparam int RatioW = edr_pkg::RATIO_W;

  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [LenW-1:0]   longer_length;
    logic [RatioW-1:0] ratio;
    logic              truncated;
  } edit_score_t;

  logic [CharW-1:0]  first_chars  [MAX_LEN];
  logic [CharW-1:0]  second_chars [MAX_LEN];
  int unsigned       first_len;
  int unsigned       second_len;
  logic              dropped;
  edit_score_t       pending_scores [$];
  int unsigned       score_index;
  int unsigned       mismatch_total;

  assign fail_count_o = mismatch_total;

  task automatic report_mismatch(input string msg);
    $display("ERROR: result %0d: %s", score_index, msg);
    mismatch_total++;
  endtask

  // Unit-cost Levenshtein distance over one rolling row, then the Q1.16 ratio.
  function automatic edit_score_t score_strings();
    int unsigned row [MAX_LEN+1];
    int unsigned diag;
    int unsigned above;
    int unsigned best;
    int unsigned longer;
    int unsigned edit_dist;
    logic [63:0] scaled;
    edit_score_t res;
    longer = (first_len > second_len) ? first_len : second_len;
    edit_dist = 0;
    res = '0;
    if (longer != 0) begin
      for (int j = 0; j <= second_len; j++) row[j] = j;
      for (int i = 1; i <= first_len; i++) begin
        diag = row[0];
        row[0] = i;
        for (int j = 1; j <= second_len; j++) begin
          above = row[j];
          best = diag + ((first_chars[i-1] == second_chars[j-1]) ? 0 : 1);
          if (above + 1 < best) best = above + 1;
          if (row[j-1] + 1 < best) best = row[j-1] + 1;
          row[j] = best;
          diag = above;
        end
      end
      edit_dist = row[second_len];
      scaled = 64'(edit_dist) << edr_pkg::FRAC_BITS;
      res.ratio = RatioW'(scaled / 64'(longer));
    end
    res.distance = DistW'(edit_dist);
    res.longer_length = LenW'(longer);
    res.truncated = dropped;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    edit_score_t want;
    if (!rst_ni) begin
      first_len = 0;
      second_len = 0;
      dropped = 1'b0;
      pending_scores.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_scores.size() == 0) begin
          report_mismatch("result emitted with no compute request outstanding");
        end else begin
          want = pending_scores.pop_front();
          if (distance_i !== want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d", distance_i, want.distance));
          if (longer_length_i !== want.longer_length)
            report_mismatch($sformatf("longer_length %0d, expected %0d",
                                      longer_length_i, want.longer_length));
          if (ratio_i !== want.ratio)
            report_mismatch($sformatf("ratio %h, expected %h", ratio_i, want.ratio));
          if (truncated_i !== want.truncated)
            report_mismatch($sformatf("truncated %b, expected %b", truncated_i, want.truncated));
        end
        score_index++;
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          edr_pkg::OP_APPEND_FIRST: begin
            if (first_len < MAX_LEN) begin
              first_chars[first_len] = ch_i;
              first_len++;
            end else begin
              dropped = 1'b1;
            end
          end
          edr_pkg::OP_APPEND_SECOND: begin
            if (second_len < MAX_LEN) begin
              second_chars[second_len] = ch_i;
              second_len++;
            end else begin
              dropped = 1'b1;
            end
          end
          edr_pkg::OP_COMPUTE: begin
            pending_scores.push_back(score_strings());
            first_len = 0;
            second_len = 0;
            dropped = 1'b0;
          end
          default: ;
        endcase
      end
      pending_o <= pending_scores.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the edit distance ratio engine testbench: clock, reset, request stimulus,
// receiver stalls and the verdict. Depends on edr_pkg, the engine and the checker.
`timescale 1ns / 100ps

module testbench;

  localparam int CharW = edr_pkg::CHAR_W;

  // The op code the engine does not define; such requests must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned TOTAL_REQUESTS = 910;
  localparam int unsigned SETTLE_CYCLES  = 300;
  // The limit allows for every request being as slow as the slowest compute
  // (two full strings) plus the longest stall and gap, taken more than three
  // times over.
  localparam int unsigned CYCLE_LIMIT    = 30_000_000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    op_i = edr_pkg::OP_APPEND_FIRST;
  logic [CharW-1:0]              ch_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [edr_pkg::DIST_W-1:0]    distance_o;
  logic [edr_pkg::LEN_W-1:0]     longer_length_o;
  logic [edr_pkg::RATIO_W-1:0]   ratio_o;
  logic                          truncated_o;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  edit_distance_ratio_engine_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .ch_i            (ch_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .distance_o      (distance_o),
    .longer_length_o (longer_length_o),
    .ratio_o         (ratio_o),
    .truncated_o     (truncated_o)
  );

  edit_distance_ratio_checker distance_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .op_i            (op_i),
    .ch_i            (ch_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .distance_i      (distance_o),
    .longer_length_i (longer_length_o),
    .ratio_i         (ratio_o),
    .truncated_i     (truncated_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_results)
  );

  // Drives one request and returns at the edge where it is accepted. Valid is
  // left high, so a following request goes out back to back with no gap.
  task automatic send_request(input logic [1:0] op, input logic [CharW-1:0] ch);
    in_valid_i <= 1'b1;
    op_i <= op;
    ch_i <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  // Random idle time between requests: usually none or a short one, now and
  // then a long one. A burst set never idles.
  task automatic sender_pause(input bit burst);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    len = 0;
    if (!burst) begin
      if (r >= 60 && r < 92) len = $urandom_range(1, 3);
      else if (r >= 92) len = $urandom_range(8, 60);
    end
    if (len != 0) begin
      in_valid_i <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // Holds the request channel idle until every outstanding compute has been
  // answered. The first edge is skipped so the checker's count is current.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // Either any byte at all, or one of four neighbors of a base byte so that
  // the two strings share characters often.
  function automatic logic [CharW-1:0] random_char(input bit narrow,
                                                   input logic [CharW-1:0] base);
    if (narrow) return base + CharW'($urandom_range(0, 3));
    return CharW'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned random_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 10);
    if (r < 88) return $urandom_range(11, 40);
    if (r < 96) return $urandom_range(41, 64);
    return $urandom_range(65, 72);
  endfunction

  // One well-formed set: two strings loaded in a random interleaving, then a
  // compute. Most sets use short strings. The second string is sometimes an
  // edited copy of the first, which keeps distances small and exercises the
  // match path of the sweep. The first set overflows both stores with
  // disjoint alphabets, the second fills both exactly.
  task automatic run_random_set(input int unsigned set_index);
    logic [CharW-1:0] first_seq [$];
    logic [CharW-1:0] second_seq [$];
    logic [CharW-1:0] base_a;
    logic [CharW-1:0] base_b;
    int unsigned m;
    int unsigned n;
    int unsigned mode;
    int unsigned pos;
    int unsigned i;
    int unsigned j;
    bit narrow;
    bit burst;
    mode = $urandom_range(0, 2);
    narrow = (mode != 0);
    base_a = CharW'($urandom_range(0, 255));
    base_b = $urandom_range(0, 1) ? base_a : CharW'($urandom_range(0, 255));
    burst = ($urandom_range(0, 3) == 0);
    m = random_length();
    n = random_length();
    if (set_index == 0) begin
      m = 70;
      n = 67;
      narrow = 1'b1;
      mode = 1;
      base_a = 8'h10;
      base_b = 8'hA0;
    end else if (set_index == 1) begin
      m = 64;
      n = 64;
      mode = 0;
      narrow = 1'b0;
    end
    repeat (m) first_seq.push_back(random_char(narrow, base_a));
    if (mode == 2) begin
      second_seq = first_seq;
      repeat ($urandom_range(0, 4)) begin
        pos = $urandom_range(0, second_seq.size());
        case ($urandom_range(0, 2))
          0: second_seq.insert(pos, random_char(narrow, base_a));
          1: if (pos < second_seq.size()) second_seq.delete(pos);
          default: if (pos < second_seq.size()) second_seq[pos] = random_char(narrow, base_a);
        endcase
      end
      while (second_seq.size() > 72) void'(second_seq.pop_back());
    end else begin
      repeat (n) second_seq.push_back(random_char(narrow, base_b));
    end

    i = 0;
    j = 0;
    while (i < first_seq.size() || j < second_seq.size()) begin
      if ($urandom_range(0, 29) == 0) begin
        // Noise: an undefined op code in the middle of loading.
        send_request(OP_UNUSED, CharW'($urandom_range(0, 255)));
      end else if (j >= second_seq.size() || (i < first_seq.size() && $urandom_range(0, 1))) begin
        send_request(edr_pkg::OP_APPEND_FIRST, first_seq[i]);
        i++;
      end else begin
        send_request(edr_pkg::OP_APPEND_SECOND, second_seq[j]);
        j++;
      end
      sender_pause(burst);
    end
    // A few sets end without a compute, so their characters run on into the
    // next set.
    if ($urandom_range(0, 19) != 0) begin
      send_request(edr_pkg::OP_COMPUTE, CharW'($urandom_range(0, 255)));
      sender_pause(burst);
    end
  endtask

  // Receiver: random stretches of taking and stalling, mostly short,
  // with a few long stalls and long stall-free windows.
  initial begin
    int unsigned r;
    int unsigned len;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(50, 300);
      end else if (r < 55) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 6);
      end else if (r < 93) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(20, 200);
      end
      repeat (len - 1) @(posedge clk_i);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: cycle limit reached");
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned set_index;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Compute on two empty strings must give all zeros.
    send_request(edr_pkg::OP_COMPUTE, 8'h00);
    // The undefined op code is ignored, character bits all ones.
    send_request(OP_UNUSED, 8'hFF);
    // Single characters at both byte extremes: one substitution, ratio 1.0.
    send_request(edr_pkg::OP_APPEND_FIRST, 8'h00);
    send_request(edr_pkg::OP_APPEND_SECOND, 8'hFF);
    send_request(edr_pkg::OP_COMPUTE, 8'hFF);
    // Equal strings with an ignored request in between: distance 0.
    send_request(edr_pkg::OP_APPEND_FIRST, 8'hFF);
    send_request(edr_pkg::OP_APPEND_FIRST, 8'h00);
    send_request(OP_UNUSED, 8'h00);
    send_request(edr_pkg::OP_APPEND_SECOND, 8'hFF);
    send_request(edr_pkg::OP_APPEND_SECOND, 8'h00);
    send_request(edr_pkg::OP_COMPUTE, 8'h00);
    // Only the first string loaded: distance equals its length.
    send_request(edr_pkg::OP_APPEND_FIRST, 8'h61);
    send_request(edr_pkg::OP_APPEND_FIRST, 8'h62);
    send_request(edr_pkg::OP_APPEND_FIRST, 8'h63);
    send_request(edr_pkg::OP_COMPUTE, 8'h00);
    // Only the second string loaded.
    send_request(edr_pkg::OP_APPEND_SECOND, 8'h55);
    send_request(edr_pkg::OP_APPEND_SECOND, 8'hAA);
    send_request(edr_pkg::OP_COMPUTE, 8'h00);
    // Interleaved loading with a transposition and a longer second string.
    send_request(edr_pkg::OP_APPEND_FIRST, 8'h61);
    send_request(edr_pkg::OP_APPEND_SECOND, 8'h62);
    send_request(edr_pkg::OP_APPEND_FIRST, 8'h62);
    send_request(edr_pkg::OP_APPEND_SECOND, 8'h61);
    send_request(edr_pkg::OP_APPEND_SECOND, 8'h63);
    send_request(edr_pkg::OP_COMPUTE, 8'h00);

    // Hold off until every directed result is back before the random sets.
    wait_for_results();

    // Random sets. Every eighth set, and now and then at random, the sender
    // waits for the results to drain, so compute also starts on an idle block.
    set_index = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      run_random_set(set_index);
      if (set_index % 8 == 7 || $urandom_range(0, 9) == 0) wait_for_results();
      set_index++;
    end
    // Score whatever characters are left over so the run ends on a compute.
    send_request(edr_pkg::OP_COMPUTE, 8'h00);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    // Extra cycles catch any result that should never have been emitted.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
